/* src/bio_pkg.sv */
// Shared constants and codes for the bipolar impulse oscillator.
`default_nettype none
package bio_pkg;

  localparam int CHANNELS_DEF      = 64;
  localparam int FRACTION_BITS_DEF = 24;

  localparam int CHANNEL_W   = 6;
  localparam int FREQ_W      = 24;
  localparam int WIDTH_LVL_W = 27;
  localparam int SYNC_LVL_W  = 27;
  localparam int OFFSET_W    = 31;
  localparam int IMPULSE_W   = 2;

  // Fraction bits of the product |frequency_hz| * step_per_hz.
  localparam int PROD_FRAC = 48;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_PER_HZ  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_ENABLED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOFT_SYNC    = 2'd2;

  localparam logic [CFG_DATA_W-1:0] STEP_PER_HZ_RST = 32'd22906492;

  localparam logic signed [IMPULSE_W-1:0] IMP_POS  = 2'sb01;
  localparam logic signed [IMPULSE_W-1:0] IMP_ZERO = 2'sb00;
  localparam logic signed [IMPULSE_W-1:0] IMP_NEG  = 2'sb11;

endpackage
`default_nettype wire

/* src/bio_if.sv */
// Valid/ready channel interfaces for samples in and impulses out.
`default_nettype none
interface bio_in_if;
  logic                                        valid;
  logic                                        ready;
  logic        [bio_pkg::CHANNEL_W-1:0]        channel;
  logic signed [bio_pkg::FREQ_W-1:0]           frequency_hz;
  logic signed [bio_pkg::WIDTH_LVL_W-1:0]      width_level;
  logic signed [bio_pkg::SYNC_LVL_W-1:0]       sync_level;
  logic signed [bio_pkg::OFFSET_W-1:0]         offset_level;

  modport source (output valid, channel, frequency_hz, width_level, sync_level, offset_level,
                  input ready);
  modport sink   (input valid, channel, frequency_hz, width_level, sync_level, offset_level,
                  output ready);
endinterface

interface bio_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [bio_pkg::IMPULSE_W-1:0]  impulse;

  modport source (output valid, impulse, input ready);
  modport sink   (input valid, impulse, output ready);
endinterface
`default_nettype wire

/* src/bipolar_impulse_oscillator.sv */
// Multichannel edge-impulse oscillator: per-channel state in one memory, read-modify-write.
// A transferred sample is held in the stage 1 registers, then its impulse in out_imp_r.
// Throughput: one sample per cycle, any channel mix, unless out_s stalls; single memory
//   read at transfer, write-back as stage 1 advances, forwarding for same-channel pairs.
// Reset: config registers take their reset values; then a clearing pass over all CHANNELS
//   entries zeroes the channel memory, with in_s.ready low until it ends.
`default_nettype none
module bipolar_impulse_oscillator #(
  parameter int CHANNELS      = bio_pkg::CHANNELS_DEF,
  parameter int FRACTION_BITS = bio_pkg::FRACTION_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  bio_in_if.sink                               in_s,
  bio_out_if.source                            out_s,
  input  wire                                  cfg_wr_en,
  input  wire  [bio_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [bio_pkg::CFG_DATA_W-1:0]       cfg_data
);

  // ---------------------------------------------------------------- geometry
  localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PHASE_W  = FRACTION_BITS + 3;
  localparam int CALC_W   = ((PHASE_W > 32) ? PHASE_W : 32) + 3;
  localparam int OFF_W    = bio_pkg::OFFSET_W;
  localparam int LVL_W    = bio_pkg::IMPULSE_W;
  localparam int FREQ_W   = bio_pkg::FREQ_W;
  localparam int WID_W    = bio_pkg::WIDTH_LVL_W;
  localparam int SYN_W    = bio_pkg::SYNC_LVL_W;
  localparam int CFG_W    = bio_pkg::CFG_DATA_W;
  localparam int PROD_W   = FREQ_W + CFG_W;
  localparam int SHIFT    = bio_pkg::PROD_FRAC - FRACTION_BITS;
  localparam int IN_CH_N  = 2 ** bio_pkg::CHANNEL_W;

  // Memory entry layout: {direction_down, previous_level, previous_offset, phase_acc}
  localparam int ENT_W    = PHASE_W + OFF_W + LVL_W + 1;
  localparam int OFF_LSB  = PHASE_W;
  localparam int LVL_LSB  = PHASE_W + OFF_W;
  localparam int DIR_BIT  = PHASE_W + OFF_W + LVL_W;

  localparam logic signed [CALC_W-1:0] ONE_C =
    {{(CALC_W-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [PROD_W-1:0] ONE_P =
    {{(PROD_W-FRACTION_BITS-1){1'b0}}, 1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [CALC_W-1:0] FRAC_MASK = ONE_C - CALC_W'(1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CHANNELS - 1);

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] step_per_hz_r;
  logic             sync_enabled_r;
  logic             soft_sync_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_per_hz_r  <= bio_pkg::STEP_PER_HZ_RST;
      sync_enabled_r <= 1'b0;
      soft_sync_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        bio_pkg::REG_STEP_PER_HZ:  step_per_hz_r  <= cfg_data;
        bio_pkg::REG_SYNC_ENABLED: sync_enabled_r <= cfg_data[0];
        bio_pkg::REG_SOFT_SYNC:    soft_sync_r    <= cfg_data[0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------- channel fold
  // Incoming channel numbers at or above the channel count wrap around; small constant table.
  logic [ADDR_W-1:0] chan_map [IN_CH_N];
  for (genvar g = 0; g < IN_CH_N; g++) begin : g_chan_map
    assign chan_map[g] = ADDR_W'(g % CHANNELS);
  end

  // ---------------------------------------------------------------- control
  logic              clr_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic              s1_valid_r;
  logic              out_valid_r;
  logic              adv;          // stage 1 moves forward this cycle
  logic              in_xfer;

  // Stage 1 may move on when it is empty or the output slot frees up.
  assign adv      = !s1_valid_r || !out_valid_r || out_s.ready;
  assign in_s.ready = adv && !clr_r;
  assign in_xfer  = in_s.valid && in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_cnt_r <= '0;
    end else if (clr_r) begin
      clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (clr_cnt_r == LAST_ADDR) begin
        clr_r <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- stage 0
  // Frequency magnitude times step_per_hz, registered before any later math.
  logic [FREQ_W-1:0] hz_mag;
  logic [PROD_W-1:0] prod;
  logic [ADDR_W-1:0] rd_addr;

  assign hz_mag  = in_s.frequency_hz[FREQ_W-1] ? FREQ_W'(-in_s.frequency_hz)
                                               : FREQ_W'(in_s.frequency_hz);
  assign prod    = PROD_W'(hz_mag) * PROD_W'(step_per_hz_r);
  assign rd_addr = chan_map[in_s.channel];

  logic [ADDR_W-1:0]        s1_addr_r;
  logic [PROD_W-1:0]        s1_prod_r;
  logic                     s1_hz_neg_r;
  logic signed [WID_W-1:0]  s1_width_r;
  logic signed [SYN_W-1:0]  s1_sync_r;
  logic signed [OFF_W-1:0]  s1_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_xfer;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_addr_r   <= rd_addr;
      s1_prod_r   <= prod;
      s1_hz_neg_r <= in_s.frequency_hz[FREQ_W-1];
      s1_width_r  <= in_s.width_level;
      s1_sync_r   <= in_s.sync_level;
      s1_offset_r <= in_s.offset_level;
    end
  end

  // ---------------------------------------------------------------- channel memory
  logic [ENT_W-1:0]  mem [CHANNELS];
  logic [ENT_W-1:0]  rd_r;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;
  logic [ENT_W-1:0]  wb_ent;       // updated entry of the item in stage 1

  assign mem_we  = clr_r || (adv && s1_valid_r);
  assign wr_addr = clr_r ? clr_cnt_r : s1_addr_r;
  assign wr_data = clr_r ? '0 : wb_ent;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (adv) begin
      rd_r <= mem[rd_addr];
    end
  end

  // Same channel written back while being read: take the new entry instead.
  logic             fwd_r;
  logic [ENT_W-1:0] fwd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (adv) begin
      fwd_r <= s1_valid_r && (s1_addr_r == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_data_r <= wb_ent;
    end
  end

  // ---------------------------------------------------------------- stage 1 math
  logic [ENT_W-1:0]          cur_ent;
  logic signed [PHASE_W-1:0] st_phase;
  logic signed [OFF_W-1:0]   st_offset;
  logic signed [LVL_W-1:0]   st_level;
  logic                      st_dir;

  assign cur_ent   = fwd_r ? fwd_data_r : rd_r;
  assign st_phase  = cur_ent[PHASE_W-1:0];
  assign st_offset = cur_ent[LVL_LSB-1:OFF_LSB];
  assign st_level  = cur_ent[DIR_BIT-1:LVL_LSB];
  assign st_dir    = cur_ent[DIR_BIT];

  logic [PROD_W-1:0]         prod_sh;
  logic [CALC_W-1:0]         step_mag;
  logic signed [CALC_W-1:0]  step_s;
  logic signed [CALC_W-1:0]  step;
  logic signed [CALC_W-1:0]  width_c;
  logic signed [CALC_W-1:0]  width_x;
  logic signed [CALC_W-1:0]  trig_x;
  logic signed [CALC_W-1:0]  diff;
  logic [CALC_W-1:0]         diff_mag;
  logic [CALC_W-1:0]         rem;
  logic signed [CALC_W-1:0]  dev;
  logic                      sync_hit;
  logic signed [CALC_W-1:0]  ph0;
  logic signed [CALC_W-1:0]  ph1;
  logic signed [CALC_W-1:0]  ph2;
  logic signed [CALC_W-1:0]  ph3;
  logic signed [CALC_W-1:0]  ph_next;
  logic signed [LVL_W-1:0]   level;
  logic signed [LVL_W-1:0]   imp;
  logic                      dir_next;

  always_comb begin
    // Step: truncate to FRACTION_BITS, saturate at one, apply frequency sign, negate while soft sync runs down.
    prod_sh  = s1_prod_r >> SHIFT;
    step_mag = (prod_sh > ONE_P) ? ONE_C : prod_sh[CALC_W-1:0];
    step_s   = s1_hz_neg_r ? -signed'(step_mag) : signed'(step_mag);
    step     = (soft_sync_r && st_dir) ? -step_s : step_s;

    // Pulse width clipped to 0..one.
    width_x = {{(CALC_W-WID_W){s1_width_r[WID_W-1]}}, s1_width_r};
    if (width_x < 0) begin
      width_c = '0;
    end else if (width_x > ONE_C) begin
      width_c = ONE_C;
    end else begin
      width_c = width_x;
    end

    // Offset change, remainder toward zero modulo one.
    diff = {{(CALC_W-OFF_W){s1_offset_r[OFF_W-1]}}, s1_offset_r}
         - {{(CALC_W-OFF_W){st_offset[OFF_W-1]}}, st_offset};
    diff_mag = diff[CALC_W-1] ? unsigned'(-diff) : unsigned'(diff);
    rem      = diff_mag & FRAC_MASK;
    dev      = diff[CALC_W-1] ? -signed'(rem) : signed'(rem);

    // Sync: the target must stay inside the cycle for the current direction.
    trig_x   = {{(CALC_W-SYN_W){s1_sync_r[SYN_W-1]}}, s1_sync_r};
    sync_hit = sync_enabled_r && (trig_x > 0) &&
               ((!s1_hz_neg_r && (trig_x <= ONE_C)) || (s1_hz_neg_r && (trig_x < ONE_C)));
    dir_next = (sync_hit && soft_sync_r) ? !st_dir : st_dir;
    ph0      = (sync_hit && !soft_sync_r) ? trig_x
             : {{(CALC_W-PHASE_W){st_phase[PHASE_W-1]}}, st_phase};
    ph1      = ph0 + dev;

    if (!s1_hz_neg_r) begin
      ph2 = (ph1 < 0) ? ph1 + ONE_C : ph1;
      if (ph2 >= ONE_C) begin
        level = bio_pkg::IMP_POS;         // wrapped: force the first high sample
        ph3   = ph2 - ONE_C;
      end else if (ph2 + step >= ONE_C) begin
        level = bio_pkg::IMP_NEG;         // about to wrap: force the last low sample
        ph3   = ph2;
      end else begin
        level = (ph2 < width_c) ? bio_pkg::IMP_POS : bio_pkg::IMP_NEG;
        ph3   = ph2;
      end
    end else begin
      ph2 = (ph1 >= ONE_C) ? ph1 - ONE_C : ph1;
      if (ph2 <= 0) begin
        level = bio_pkg::IMP_NEG;
        ph3   = ph2 + ONE_C;
      end else if (ph2 + step <= 0) begin
        level = bio_pkg::IMP_POS;
        ph3   = ph2;
      end else begin
        level = (ph2 < width_c) ? bio_pkg::IMP_POS : bio_pkg::IMP_NEG;
        ph3   = ph2;
      end
    end

    ph_next = ph3 + step;

    if (level > st_level) begin
      imp = bio_pkg::IMP_POS;
    end else if (level < st_level) begin
      imp = bio_pkg::IMP_NEG;
    end else begin
      imp = bio_pkg::IMP_ZERO;
    end

    wb_ent = {dir_next, level, s1_offset_r, ph_next[PHASE_W-1:0]};
  end

  // ---------------------------------------------------------------- output register
  logic signed [LVL_W-1:0] out_imp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && s1_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_s.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_imp_r <= imp;
    end
  end

  assign out_s.valid   = out_valid_r;
  assign out_s.impulse = out_imp_r;

  // ---------------------------------------------------------------- checks
  // A sample leaving stage 1 must land in the output slot.
  assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_valid_r) |=> out_valid_r)
    else $error("stage 1 result lost");

  // Impulse is only ever -1, 0 or +1.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_imp_r != 2'b10))
    else $error("impulse out of range");

  // No sample may be in flight while the memory is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !s1_valid_r)
    else $error("sample accepted during clearing pass");

  // A freshly loaded forward flag always comes from a write-back in the cycle before.
  assert property (@(posedge clk) disable iff (!rst_n)
    (fwd_r && $past(adv)) |-> ($past(mem_we) && !$past(clr_r)))
    else $error("forwarding without write-back");

endmodule
`default_nettype wire

/* tb/bipolar_impulse_oscillator_test.sv */
// Self-checking testbench for the bipolar impulse oscillator: directed and random samples.
package bio_tb_pkg;
  import bio_pkg::*;

  localparam int     PHASE_W = FRACTION_BITS_DEF + 3;
  localparam longint ONE_LVL = longint'(1) << FRACTION_BITS_DEF;
  // register index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct {
    logic        [CHANNEL_W-1:0]   channel;
    logic signed [FREQ_W-1:0]      frequency_hz;
    logic signed [WIDTH_LVL_W-1:0] width_level;
    logic signed [SYNC_LVL_W-1:0]  sync_level;
    logic signed [OFFSET_W-1:0]    offset_level;
  } sample_t;

  class impulse_scoreboard;
    logic [CFG_DATA_W-1:0]       step_per_hz;
    bit                          sync_on;
    bit                          soft_on;
    logic signed [PHASE_W-1:0]   phase_acc   [CHANNELS_DEF];
    logic signed [OFFSET_W-1:0]  last_offset [CHANNELS_DEF];
    logic signed [IMPULSE_W-1:0] last_level  [CHANNELS_DEF];
    bit                          dir_down    [CHANNELS_DEF];
    logic signed [IMPULSE_W-1:0] due_impulses [$];
    int                          failures;

    function new();
      step_per_hz = STEP_PER_HZ_RST;
      sync_on     = 1'b0;
      soft_on     = 1'b0;
      failures    = 0;
      foreach (phase_acc[i]) begin
        phase_acc[i]   = '0;
        last_offset[i] = '0;
        last_level[i]  = IMP_ZERO;
        dir_down[i]    = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEP_PER_HZ:  step_per_hz = data;
        REG_SYNC_ENABLED: sync_on = data[0];
        REG_SOFT_SYNC:    soft_on = data[0];
        default: ;
      endcase
    endfunction

    // Advance one channel by one sample and queue the impulse it must produce.
    function void note_sample(sample_t s);
      int                          ch;
      longint                      hz, wid, trig, ofs, stp, dev, ph;
      longint unsigned             mag;
      logic signed [IMPULSE_W-1:0] lvl, imp;
      ch   = int'(s.channel) % CHANNELS_DEF;
      hz   = s.frequency_hz;
      wid  = s.width_level;
      trig = s.sync_level;
      ofs  = s.offset_level;

      mag = (hz < 0) ? -hz : hz;
      mag = mag * step_per_hz;
      mag = mag >> (PROD_FRAC - FRACTION_BITS_DEF);
      if (mag > ONE_LVL) mag = ONE_LVL;
      stp = (hz < 0) ? -longint'(mag) : longint'(mag);

      if (wid < 0) wid = 0;
      if (wid > ONE_LVL) wid = ONE_LVL;

      dev = (ofs - longint'(last_offset[ch])) % ONE_LVL;

      if (soft_on && dir_down[ch]) stp = -stp;

      ph = phase_acc[ch];
      if (sync_on && trig > 0 &&
          ((hz >= 0 && trig <= ONE_LVL) || (hz < 0 && trig < ONE_LVL))) begin
        if (soft_on) dir_down[ch] = !dir_down[ch];
        else ph = trig;
      end

      ph = ph + dev;
      if (hz >= 0) begin
        if (ph < 0) ph = ph + ONE_LVL;
        if (ph >= ONE_LVL) begin
          lvl = IMP_POS;
          ph  = ph - ONE_LVL;
        end else if (ph + stp >= ONE_LVL) begin
          lvl = IMP_NEG;
        end else begin
          lvl = (ph < wid) ? IMP_POS : IMP_NEG;
        end
      end else begin
        if (ph >= ONE_LVL) ph = ph - ONE_LVL;
        if (ph <= 0) begin
          lvl = IMP_NEG;
          ph  = ph + ONE_LVL;
        end else if (ph + stp <= 0) begin
          lvl = IMP_POS;
        end else begin
          lvl = (ph < wid) ? IMP_POS : IMP_NEG;
        end
      end

      if (lvl > last_level[ch]) imp = IMP_POS;
      else if (lvl < last_level[ch]) imp = IMP_NEG;
      else imp = IMP_ZERO;
      due_impulses.push_back(imp);

      phase_acc[ch]   = PHASE_W'(ph + stp);
      last_offset[ch] = s.offset_level;
      last_level[ch]  = lvl;
    endfunction

    function void check_impulse(logic signed [IMPULSE_W-1:0] got);
      logic signed [IMPULSE_W-1:0] want;
      if (due_impulses.size() == 0) begin
        $error("impulse: expected none, got %0d", got);
        failures++;
        return;
      end
      want = due_impulses.pop_front();
      if (got !== want) begin
        $error("impulse: expected %0d, got %0d", want, got);
        failures++;
      end
    endfunction

    function int pending();
      return due_impulses.size();
    endfunction
  endclass
endpackage

module bipolar_impulse_oscillator_test;
  import bio_pkg::*;
  import bio_tb_pkg::*;

  // Slowest run: ~1825 samples, each waiting out a sender gap of up to MAX_GAP and a
  // receiver that stalls at a stall_pct of 86, plus the clearing pass.
  // That total stays far below the limit.
  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int MAX_GAP         = 8;
  localparam int DRAIN_CYCLES    = 8;   // idle time after draining, to catch stray impulses

  // Per random phase: bit p set means sync / soft sync is on in phase p.
  localparam logic [RANDOM_PHASES-1:0] SYNC_PHASES = 8'b1100_1110;
  localparam logic [RANDOM_PHASES-1:0] SOFT_PHASES = 8'b1011_0100;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bio_in_if  in_if ();
  bio_out_if out_if ();

  bipolar_impulse_oscillator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_s     (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  impulse_scoreboard board;

  int  gap_pct;      // chance in 100 that the sender idles before a sample
  int  stall_pct;    // chance in 100 that the receiver stalls in a cycle
  bit  calm;         // no idling on either side while set
  int  cycle_count;
  logic signed [OFFSET_W-1:0] recent_offset [CHANNELS_DEF];

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Receiver: ready changes only at the falling edge.
  always @(negedge clk) begin
    out_if.ready = calm || ($urandom_range(0, 99) >= stall_pct);
  end

  // Both channels are observed at the rising edge. The result side goes first, but a
  // sample never produces its impulse in the same cycle it transfers, so order is moot.
  always @(posedge clk) begin : observe
    sample_t taken;
    cycle_count++;
    if (out_if.valid && out_if.ready) board.check_impulse(out_if.impulse);
    if (in_if.valid && in_if.ready) begin
      taken.channel      = in_if.channel;
      taken.frequency_hz = in_if.frequency_hz;
      taken.width_level  = in_if.width_level;
      taken.sync_level   = in_if.sync_level;
      taken.offset_level = in_if.offset_level;
      board.note_sample(taken);
    end
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("bipolar_impulse_oscillator_test: FAIL");
    $finish;
  end

  function automatic sample_t make_sample(int ch, longint hz, longint wid, longint sync,
                                          longint ofs);
    sample_t s;
    s.channel      = CHANNEL_W'(ch);
    s.frequency_hz = FREQ_W'(hz);
    s.width_level  = WIDTH_LVL_W'(wid);
    s.sync_level   = SYNC_LVL_W'(sync);
    s.offset_level = OFFSET_W'(ofs);
    return s;
  endfunction

  // Mostly a few busy channels with plausible tones and slowly moving offsets, so phases
  // really wrap and edges come; the rest is full-range noise on every field.
  function automatic sample_t random_sample();
    sample_t s;
    int      r;
    int      ch;
    longint  delta;
    ch = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 3) : $urandom_range(0, 63);
    s.channel = CHANNEL_W'(ch);

    r = $urandom_range(0, 99);
    if (r < 60) begin
      s.frequency_hz = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 1)) s.frequency_hz = -s.frequency_hz;
    end else if (r < 75) begin
      s.frequency_hz = $urandom();
    end else if (r < 85) begin
      s.frequency_hz = '0;
    end else begin
      s.frequency_hz = $urandom_range(0, 1) ? {1'b0, {(FREQ_W-1){1'b1}}}
                                             : {1'b1, {(FREQ_W-1){1'b0}}};
    end

    r = $urandom_range(0, 99);
    if (r < 70) s.width_level = $urandom_range(0, ONE_LVL);
    else if (r < 85) s.width_level = $urandom();
    else begin
      case ($urandom_range(0, 3))
        0:       s.width_level = '0;
        1:       s.width_level = ONE_LVL;
        2:       s.width_level = -1;
        default: s.width_level = ONE_LVL + 1;
      endcase
    end

    r = $urandom_range(0, 99);
    if (r < 75) begin
      s.sync_level = $urandom_range(0, 1) ? 0 : -$urandom_range(1, ONE_LVL);
    end else if (r < 90) begin
      s.sync_level = ($urandom_range(0, 3) == 0) ? ONE_LVL : $urandom_range(1, ONE_LVL);
    end else begin
      s.sync_level = $urandom();
    end

    r = $urandom_range(0, 99);
    if (r < 70) begin
      delta = $urandom_range(0, ONE_LVL / 4);
      if ($urandom_range(0, 1)) delta = -delta;
      s.offset_level = OFFSET_W'(longint'(recent_offset[ch]) + delta);
    end else if (r < 80) begin
      s.offset_level = recent_offset[ch];
    end else begin
      s.offset_level = $urandom();
    end
    recent_offset[ch] = s.offset_level;
    return s;
  endfunction

  // One sample, optionally after an idle gap; returns at the edge of its transfer.
  task automatic send_sample(input sample_t s, input bit may_idle);
    int gap;
    gap = 0;
    if (may_idle && !calm && $urandom_range(0, 99) < gap_pct) gap = $urandom_range(1, MAX_GAP);
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.channel      = s.channel;
    in_if.frequency_hz = s.frequency_hz;
    in_if.width_level  = s.width_level;
    in_if.sync_level   = s.sync_level;
    in_if.offset_level = s.offset_level;
    in_if.valid        = 1'b1;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop sending and wait until every queued impulse has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_if.valid = 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.write_reg(idx, data);
  endtask

  initial begin
    board              = new();
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_index          = REG_STEP_PER_HZ;
    cfg_data           = '0;
    in_if.valid        = 1'b0;
    in_if.channel      = '0;
    in_if.frequency_hz = '0;
    in_if.width_level  = '0;
    in_if.sync_level   = '0;
    in_if.offset_level = '0;
    out_if.ready       = 1'b0;
    gap_pct            = 0;
    stall_pct          = 0;
    calm               = 1'b1;
    cycle_count        = 0;
    foreach (recent_offset[i]) recent_offset[i] = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- directed: reset settings, field extremes, offset jumps beyond one cycle
    send_sample(make_sample(0, 0, ONE_LVL / 2, 0, 0), 1'b0);
    send_sample(make_sample(0, 8388607, ONE_LVL / 2, 0, 0), 1'b0);
    send_sample(make_sample(1, -8388608, -67108864, 0, 1073741823), 1'b0);
    send_sample(make_sample(63, 256, 67108863, -67108864, -1073741824), 1'b0);
    send_sample(make_sample(1, -256, ONE_LVL, 0, -1073741824), 1'b0);
    send_sample(make_sample(2, 4096 * 256, 0, 0, ONE_LVL * 3 / 2), 1'b0);
    send_sample(make_sample(2, 4096 * 256, 0, 0, -ONE_LVL * 3 / 2), 1'b0);
    // sync level present but sync is off
    send_sample(make_sample(2, -4096 * 256, ONE_LVL, 67108863, 0), 1'b0);

    // step saturates at one cycle per sample in both directions
    wait_drained();
    write_reg(REG_STEP_PER_HZ, '1);
    send_sample(make_sample(3, 256, ONE_LVL / 2, 0, 0), 1'b0);
    send_sample(make_sample(3, 8388607, ONE_LVL / 2, 0, 0), 1'b0);
    send_sample(make_sample(3, -8388608, ONE_LVL / 2, 0, 0), 1'b0);

    // zero step: only the offset moves the phase
    wait_drained();
    write_reg(REG_STEP_PER_HZ, '0);
    send_sample(make_sample(4, 8388607, ONE_LVL / 2, 0, ONE_LVL / 2), 1'b0);
    send_sample(make_sample(4, 8388607, ONE_LVL / 2, 0, ONE_LVL), 1'b0);

    // hard sync: acceptance edge at one differs with frequency sign
    wait_drained();
    write_reg(REG_STEP_PER_HZ, STEP_PER_HZ_RST);
    write_reg(REG_SYNC_ENABLED, 1);
    send_sample(make_sample(5, 1000 * 256, ONE_LVL / 2, ONE_LVL, 0), 1'b0);
    send_sample(make_sample(6, -1000 * 256, ONE_LVL / 2, ONE_LVL, 0), 1'b0);
    send_sample(make_sample(6, -1000 * 256, ONE_LVL / 2, ONE_LVL - 1, 0), 1'b0);
    send_sample(make_sample(5, 1000 * 256, ONE_LVL / 2, ONE_LVL + 1, 0), 1'b0);
    send_sample(make_sample(5, 1000 * 256, ONE_LVL / 4, 1, 0), 1'b0);

    // soft sync: direction flips, then the step runs backwards
    wait_drained();
    write_reg(REG_SOFT_SYNC, 1);
    send_sample(make_sample(7, 2000 * 256, ONE_LVL / 2, ONE_LVL / 2, 0), 1'b0);
    send_sample(make_sample(7, 2000 * 256, ONE_LVL / 2, 0, 0), 1'b0);
    send_sample(make_sample(7, -2000 * 256, ONE_LVL / 2, ONE_LVL / 4, 0), 1'b0);
    send_sample(make_sample(7, -2000 * 256, ONE_LVL / 2, 0, ONE_LVL / 8), 1'b0);

    // write to an index with no register must change nothing
    wait_drained();
    write_reg(REG_SPARE, '1);
    send_sample(make_sample(8, 3000 * 256, ONE_LVL / 3, 0, 0), 1'b0);

    // --- random phases, each with its own settings and idling pattern
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      case (p)
        0, 4:    write_reg(REG_STEP_PER_HZ, STEP_PER_HZ_RST);
        1:       write_reg(REG_STEP_PER_HZ, '1);
        3:       write_reg(REG_STEP_PER_HZ, '0);
        5:       write_reg(REG_STEP_PER_HZ, $urandom_range(0, 1 << 26));
        6:       write_reg(REG_STEP_PER_HZ, STEP_PER_HZ_RST << 2);
        default: write_reg(REG_STEP_PER_HZ, $urandom());
      endcase
      write_reg(REG_SYNC_ENABLED, SYNC_PHASES[p]);
      write_reg(REG_SOFT_SYNC, SOFT_PHASES[p]);

      // none / sender idles / receiver stalls / both, in turn
      gap_pct   = (p % 4 == 1) ? 86 : (p % 4 == 3) ? 18 : 0;
      stall_pct = (p % 4 == 2) ? 86 : (p % 4 == 3) ? 18 : 0;

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        calm = ((i / 32) % 3 == 2);   // every third stretch runs at full rate
        if (i == ITEMS_PER_PHASE / 2) wait_drained();
        send_sample(random_sample(), 1'b1);
      end
    end

    calm = 1'b1;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("bipolar_impulse_oscillator_test: PASS");
    end else begin
      $display("bipolar_impulse_oscillator_test: FAIL");
    end
    $finish;
  end

endmodule
